>>> rtl/lzwd_pkg.sv
`timescale 1ns / 1ps
package lzwd_pkg;

  localparam int DEF_TOP_BITS     = 13;
  localparam int DEF_DICT_ENTRIES = 8192;
  localparam int START_BITS       = 9;
  localparam int MIN_MAX_BITS     = 12;
  localparam int CLEAR_CODE       = 256;
  localparam int LIT_CODES        = 256;
  localparam logic [3:0] RESET_MAX_BITS = 4'd13;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PULL,
    ST_POP,
    ST_TAKE,
    ST_WALK_RD,
    ST_WALK_DT,
    ST_FINISH,
    ST_AFTER
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic push;
    logic pop_rd;
    logic emit_pop;
    logic emit_flags;
    logic set_limit;
    logic take;
    logic walk_rd;
    logic walk_dt;
    logic finish;
    logic emit_after;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic stack_nz;
    logic no_data;
    logic take_short;
    logic cur_lit;
    logic depth_room;
  } status_t;

endpackage

>>> rtl/lzwd_ram.sv
`timescale 1ns / 1ps
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lzwd_ctrl.sv
`timescale 1ns / 1ps
module lzwd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              kind,
  output logic              in_stall,
  input  lzwd_pkg::status_t sts,
  output lzwd_pkg::cmd_t    cmd
);

  lzwd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzwd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lzwd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = kind ? lzwd_pkg::ST_PULL : lzwd_pkg::ST_PUSH;
        end
      end
      lzwd_pkg::ST_PUSH: begin
        if (sts.slot_free) state_next = lzwd_pkg::ST_IDLE;
      end
      lzwd_pkg::ST_PULL: begin
        priority if (sts.stack_nz) begin
          state_next = lzwd_pkg::ST_POP;
        end else if (sts.no_data) begin
          if (sts.slot_free) state_next = lzwd_pkg::ST_IDLE;
        end else begin
          state_next = lzwd_pkg::ST_TAKE;
        end
      end
      lzwd_pkg::ST_POP: begin
        if (sts.slot_free) state_next = lzwd_pkg::ST_IDLE;
      end
      lzwd_pkg::ST_TAKE: begin
        state_next = sts.take_short ? lzwd_pkg::ST_AFTER : lzwd_pkg::ST_WALK_RD;
      end
      lzwd_pkg::ST_WALK_RD: begin
        state_next = sts.cur_lit ? lzwd_pkg::ST_FINISH : lzwd_pkg::ST_WALK_DT;
      end
      lzwd_pkg::ST_WALK_DT: begin
        state_next = sts.depth_room ? lzwd_pkg::ST_WALK_RD : lzwd_pkg::ST_FINISH;
      end
      lzwd_pkg::ST_FINISH: begin
        state_next = lzwd_pkg::ST_AFTER;
      end
      lzwd_pkg::ST_AFTER: begin
        if (sts.slot_free) state_next = lzwd_pkg::ST_IDLE;
      end
      default: state_next = lzwd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      lzwd_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      lzwd_pkg::ST_PUSH: cmd.push = sts.slot_free;
      lzwd_pkg::ST_PULL: begin
        priority if (sts.stack_nz) begin
          cmd.pop_rd = 1'b1;
        end else if (sts.no_data) begin
          cmd.emit_flags = sts.slot_free;
        end else begin
          cmd.set_limit = 1'b1;
        end
      end
      lzwd_pkg::ST_POP:     cmd.emit_pop = sts.slot_free;
      lzwd_pkg::ST_TAKE:    cmd.take = 1'b1;
      lzwd_pkg::ST_WALK_RD: cmd.walk_rd = 1'b1;
      lzwd_pkg::ST_WALK_DT: cmd.walk_dt = 1'b1;
      lzwd_pkg::ST_FINISH:  cmd.finish = 1'b1;
      lzwd_pkg::ST_AFTER:   cmd.emit_after = sts.slot_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/lzwd_dp.sv
`timescale 1ns / 1ps
module lzwd_dp #(
  parameter int TopBits     = lzwd_pkg::DEF_TOP_BITS,
  parameter int DictEntries = lzwd_pkg::DEF_DICT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  lzwd_pkg::cmd_t    cmd,
  output lzwd_pkg::status_t sts,
  input  logic [7:0]        in_data,
  input  logic              in_last,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data,
  input  logic              res_stall,
  output logic              res_valid,
  output logic [7:0]        out_byte,
  output logic              out_valid,
  output logic              byte_accepted,
  output logic              need_input,
  output logic              done_res
);

  localparam int CW  = TopBits;
  localparam int NW  = TopBits + 1;
  localparam int AW  = $clog2(DictEntries);
  localparam int CWW = $clog2(TopBits + 1);
  localparam int GIW = $clog2(TopBits);
  localparam int OW  = $clog2(TopBits * 9 + 1);
  localparam int GW  = TopBits * 8;

  // latched item
  logic [7:0] item_byte;
  logic       item_last;

  logic [3:0]     max_code_bits;
  logic [7:0]     grp [TopBits];
  logic [CWW-1:0] group_fill;
  logic [OW-1:0]  bit_offset;
  logic [OW-1:0]  group_bit_limit;
  logic [CWW-1:0] code_width;
  logic [NW-1:0]  width_limit;
  logic [NW-1:0]  next_free_code;
  logic [CW-1:0]  previous_code;
  logic [7:0]     first_char;
  logic           clear_pending;
  logic [AW-1:0]  stack_depth;
  logic           started;
  logic           input_ended;
  logic [CW-1:0]  incode;
  logic [CW-1:0]  cur;
  logic [AW-1:0]  depth;
  logic [7:0]     walk_fc;
  logic           pend_clear;

  logic [CWW-1:0] mb;
  logic [GW-1:0]  flat;
  logic [GW-1:0]  shifted;
  logic [CW:0]    mask_w;
  logic [CW-1:0]  code;
  logic [OW-1:0]  fill8;
  logic           can_load;
  logic           push_ok;
  logic           after_cond;
  logic [NW-1:0]  max_limit;
  logic           dict_room;

  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata, stk_rdata;
  logic          tbl_we;
  logic [CW-1:0] pfx_rdata;
  logic [7:0]    sfx_rdata;

  always_comb begin
    if (32'(max_code_bits) < lzwd_pkg::MIN_MAX_BITS) begin
      mb = CWW'(lzwd_pkg::MIN_MAX_BITS);
    end else if (32'(max_code_bits) > TopBits) begin
      mb = CWW'(TopBits);
    end else begin
      mb = CWW'(max_code_bits);
    end
  end

  always_comb begin
    for (int i = 0; i < TopBits; i++) begin
      flat[i*8 +: 8] = grp[i];
    end
  end

  assign shifted   = flat >> bit_offset;
  assign mask_w    = ((CW+1)'(1) << code_width) - (CW+1)'(1);
  assign code      = shifted[CW-1:0] & mask_w[CW-1:0];
  assign fill8     = OW'(group_fill) << 3;
  assign can_load  = (fill8 >= OW'(code_width)) &&
                     ((group_fill >= code_width) || input_ended);
  assign push_ok   = (group_bit_limit == '0) && (group_fill < code_width) &&
                     (32'(group_fill) < TopBits) && !input_ended;
  assign after_cond = clear_pending || (bit_offset >= group_bit_limit) ||
                      (next_free_code > width_limit);
  assign max_limit = NW'(1) << mb;
  assign dict_room = 32'(next_free_code) < DictEntries;

  assign sts.slot_free  = !res_valid || !res_stall;
  assign sts.stack_nz   = stack_depth != '0;
  assign sts.no_data    = (group_bit_limit == '0) && !can_load;
  assign sts.take_short = !started || (32'(code) == lzwd_pkg::CLEAR_CODE);
  assign sts.cur_lit    = 32'(cur) < lzwd_pkg::LIT_CODES;
  assign sts.depth_room = 32'(depth) < DictEntries - 1;

  // stack: kwkwk and chain pushes write, pulls read
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = depth;
    stk_wdata = sfx_rdata;
    if (cmd.take && !sts.take_short && ({1'b0, code} >= next_free_code)) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = first_char;
    end else if (cmd.walk_dt && sts.depth_room) begin
      stk_we = 1'b1;
    end
  end
  assign stk_re    = cmd.pop_rd;
  assign stk_raddr = stack_depth - AW'(1);
  assign tbl_we    = cmd.finish && (next_free_code < max_limit) && dict_room;

  lzwd_ram #(.WIDTH(8), .DEPTH(DictEntries)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  lzwd_ram #(.WIDTH(CW), .DEPTH(DictEntries)) u_prefix (
    .clk(clk), .we(tbl_we), .waddr(AW'(next_free_code)), .wdata(previous_code),
    .re(cmd.walk_rd), .raddr(AW'(cur)), .rdata(pfx_rdata)
  );

  lzwd_ram #(.WIDTH(8), .DEPTH(DictEntries)) u_suffix (
    .clk(clk), .we(tbl_we), .waddr(AW'(next_free_code)), .wdata(walk_fc),
    .re(cmd.walk_rd), .raddr(AW'(cur)), .rdata(sfx_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      item_byte <= in_data;
      item_last <= in_last;
    end
    if (cmd.push && push_ok) begin
      grp[group_fill[GIW-1:0]] <= item_byte;
    end
    if (cmd.take) begin
      incode <= code;
      depth  <= ({1'b0, code} >= next_free_code) ? AW'(1) : '0;
      cur    <= ({1'b0, code} >= next_free_code) ? previous_code : code;
    end
    if (cmd.walk_rd && sts.cur_lit) begin
      walk_fc <= cur[7:0];
    end
    if (cmd.walk_dt) begin
      if (sts.depth_room) begin
        depth <= depth + AW'(1);
        cur   <= pfx_rdata;
      end else begin
        walk_fc <= sfx_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_code_bits   <= lzwd_pkg::RESET_MAX_BITS;
      group_fill      <= '0;
      bit_offset      <= '0;
      group_bit_limit <= '0;
      code_width      <= CWW'(lzwd_pkg::START_BITS);
      width_limit     <= (NW'(1) << lzwd_pkg::START_BITS) - NW'(1);
      next_free_code  <= NW'(lzwd_pkg::CLEAR_CODE + 1);
      previous_code   <= '0;
      first_char      <= '0;
      clear_pending   <= 1'b0;
      stack_depth     <= '0;
      started         <= 1'b0;
      input_ended     <= 1'b0;
      pend_clear      <= 1'b0;
      res_valid       <= 1'b0;
      out_byte        <= '0;
      out_valid       <= 1'b0;
      byte_accepted   <= 1'b0;
      need_input      <= 1'b0;
      done_res        <= 1'b0;
    end else begin
      if (cfg_we) max_code_bits <= cfg_data;
      if (res_valid && !res_stall) res_valid <= 1'b0;

      if (cmd.push) begin
        if (push_ok) begin
          group_fill <= group_fill + CWW'(1);
          if (item_last) input_ended <= 1'b1;
        end
        res_valid     <= 1'b1;
        out_byte      <= '0;
        out_valid     <= 1'b0;
        byte_accepted <= push_ok;
        need_input    <= 1'b0;
        done_res      <= 1'b0;
      end

      if (cmd.pop_rd) stack_depth <= stack_depth - AW'(1);
      if (cmd.emit_pop) begin
        res_valid     <= 1'b1;
        out_byte      <= stk_rdata;
        out_valid     <= 1'b1;
        byte_accepted <= 1'b0;
        need_input    <= 1'b0;
        done_res      <= 1'b0;
      end

      if (cmd.emit_flags) begin
        res_valid     <= 1'b1;
        out_byte      <= '0;
        out_valid     <= 1'b0;
        byte_accepted <= 1'b0;
        need_input    <= !input_ended;
        done_res      <= input_ended;
      end

      if (cmd.set_limit && (group_bit_limit == '0)) begin
        group_bit_limit <= fill8 - OW'(code_width) + OW'(1);
      end

      if (cmd.take) begin
        bit_offset <= bit_offset + OW'(code_width);
        if (!started) begin
          started       <= 1'b1;
          previous_code <= code;
          first_char    <= code[7:0];
          pend_clear    <= 1'b0;
        end else if (32'(code) == lzwd_pkg::CLEAR_CODE) begin
          next_free_code <= NW'(lzwd_pkg::CLEAR_CODE);
          clear_pending  <= 1'b1;
          pend_clear     <= 1'b1;
        end
      end

      if (cmd.finish) begin
        first_char    <= walk_fc;
        pend_clear    <= 1'b0;
        previous_code <= incode;
        stack_depth   <= depth;
        if (next_free_code < max_limit) next_free_code <= next_free_code + NW'(1);
      end

      if (cmd.emit_after) begin
        res_valid     <= 1'b1;
        out_byte      <= pend_clear ? 8'd0 : first_char;
        out_valid     <= !pend_clear;
        byte_accepted <= 1'b0;
        need_input    <= 1'b0;
        done_res      <= 1'b0;
        if (after_cond) begin
          // start a new group, growing the width when the dictionary outgrew it, or resetting it after a clear
          if (next_free_code > width_limit) begin
            if (code_width < mb) begin
              code_width  <= code_width + CWW'(1);
              width_limit <= (code_width + CWW'(1) == mb) ? max_limit :
                             (NW'(1) << (code_width + CWW'(1))) - NW'(1);
            end else begin
              width_limit <= max_limit;
            end
          end
          if (clear_pending) begin
            code_width    <= CWW'(lzwd_pkg::START_BITS);
            width_limit   <= (NW'(1) << lzwd_pkg::START_BITS) - NW'(1);
            clear_pending <= 1'b0;
          end
          group_fill      <= '0;
          bit_offset      <= '0;
          group_bit_limit <= '0;
        end
      end
    end
  end

endmodule

>>> rtl/lzw_variable_width_decoder_core.sv
`timescale 1ns / 1ps
// channel   | handshake                      | payload
// input     | in_valid / in_stall (out)      | kind, in_byte, in_last
// result    | res_valid (out) / res_stall    | out_byte, out_valid, byte_accepted,
//           |                                | need_input, done_res
// config    | cfg_valid / cfg_ready (out)    | cfg_data (max_code_bits)
//
// one item at a time: a push passes the push state, a stack pull the pull and pop
// states, an empty pull the pull state, a first code or a clear pull, take and after,
// other codes add walk states (one registered-read table read per link) and finish.
// rst is synchronous; the dictionary and stack memories are not cleared.
// a waiting result does not block the next input transfer; it only holds the
// finishing step of the following item.
module lzw_variable_width_decoder_core #(
  parameter int TOP_BITS     = lzwd_pkg::DEF_TOP_BITS,
  parameter int DICT_ENTRIES = lzwd_pkg::DEF_DICT_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       byte_accepted,
  output logic       need_input,
  output logic       done_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  lzwd_pkg::cmd_t    cmd;
  lzwd_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  lzwd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .kind(kind),
    .in_stall(in_stall), .sts(sts), .cmd(cmd)
  );

  lzwd_dp #(.TopBits(TOP_BITS), .DictEntries(DICT_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_data(in_byte), .in_last(in_last),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .res_stall(res_stall), .res_valid(res_valid), .out_byte(out_byte),
    .out_valid(out_valid), .byte_accepted(byte_accepted),
    .need_input(need_input), .done_res(done_res)
  );

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $countones({out_valid, byte_accepted, need_input, done_res}) <= 1)
    else $error("more than one result flag set");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in work");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> out_byte == 8'd0)
    else $error("byte on a result without data");

endmodule
